// ----- hdl/mhe_pkg.sv -----
`timescale 1ns / 1ps

package mhe_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_APPEND = 2'd1,
    OP_BUILD  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_DN_LOAD,
    S_DN_CMP,
    S_RD
  } state_t;

  localparam int unsigned IN_VALUE_W  = 32;
  localparam int unsigned IN_INDEX_W  = 6;
  localparam int unsigned OUT_TOTAL_W = 7;

endpackage

// ----- hdl/mhe_store.sv -----
`timescale 1ns / 1ps

module mhe_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_a,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_a_r;
  logic [WIDTH-1:0] rd_data_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a_r <= mem[rd_addr_a];
    rd_data_b_r <= mem[rd_addr_b];
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

// ----- hdl/min_heap_engine_top.sv -----
`timescale 1ns / 1ps

// Binary min-heap of signed values held in one synchronous memory.
// An operation is transferred at a rising edge where start is high and busy is low;
// in_opcode selects insert, append, build or read, with in_value and in_index.
// Every operation gives exactly one result: out_valid is high for one cycle with
// out_read_data, out_min_value, out_entry_total and out_status. The receiver
// cannot stall, so a result is always transferred in the cycle it is shown.
// Append, an insert into an empty heap, a rejected operation, a build of fewer
// than two entries and a read out of range finish straight from the idle state;
// a read passes through S_RD; any other insert climbs in S_UP, one level at a
// time, until the parent is no larger or the root is reached. A build takes
// each parent from the last one down to the root through a load step
// (S_DN_LOAD) and a compare step (S_DN_CMP) that repeats for each level that
// entry sinks.
// Each heap level takes its own step because the memory has one write port and
// registered reads. busy stays high until the last write is done and falls as
// the result appears, so the next operation can be transferred at the edge that
// transfers the result; no operation is taken while another is in progress.
// Reset empties the heap; the memory itself is not cleared.
module min_heap_engine_top #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  mhe_pkg::op_t                           in_opcode,
  input  logic signed [mhe_pkg::IN_VALUE_W-1:0]  in_value,
  input  logic [mhe_pkg::IN_INDEX_W-1:0]         in_index,
  output logic                                   out_valid,
  output logic signed [31:0]                     out_read_data,
  output logic signed [31:0]                     out_min_value,
  output logic [mhe_pkg::OUT_TOTAL_W-1:0]        out_entry_total,
  output mhe_pkg::status_t                       out_status
);

  import mhe_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > IN_INDEX_W) ? CW : IN_INDEX_W;
  localparam int unsigned NW = AW + 2;

  state_t                state_r, state_nxt;
  logic [DATA_WIDTH-1:0] x_r, x_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [AW-1:0]         bp_r, bp_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [DATA_WIDTH-1:0] root_r, root_nxt;

  logic                  out_valid_r;
  logic signed [31:0]    out_read_data_r;
  logic signed [31:0]    out_min_value_r;
  logic [OUT_TOTAL_W-1:0] out_entry_total_r;
  status_t               out_status_r;

  logic                  we;
  logic [AW-1:0]         wa, ra, rb;
  logic [DATA_WIDTH-1:0] wd, rd_a, rd_b;

  logic                  fin;
  status_t               fin_status;
  logic [DATA_WIDTH-1:0] fin_rdata;

  logic signed [63:0]    vin64;
  logic [DATA_WIDTH-1:0] vin;
  logic [CW-1:0]         half;
  logic [AW-1:0]         par;
  logic [NW-1:0]         lc_w, rc_w, n_w;
  logic                  take_l, take_r;
  logic [DATA_WIDTH-1:0] best_l;
  logic [AW-1:0]         best_pos;
  logic [DATA_WIDTH-1:0] best_val;
  logic [NW-1:0]         blc_w, brc_w;
  logic [CW+OUT_TOTAL_W-1:0] total_ext;

  function automatic logic signed [31:0] to32(input logic [DATA_WIDTH-1:0] v);
    logic signed [63:0] w;
    w = 64'($signed(v));
    return w[31:0];
  endfunction

  function automatic logic [NW-1:0] lchild(input logic [AW-1:0] p);
    return {1'b0, p, 1'b1};
  endfunction

  mhe_store #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (we),
    .wr_addr   (wa),
    .wr_data   (wd),
    .rd_addr_a (ra),
    .rd_addr_b (rb),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  assign vin64 = 64'(in_value);
  assign vin   = vin64[DATA_WIDTH-1:0];
  assign half  = count_r >> 1;
  assign par   = (pos_r - AW'(1)) >> 1;
  assign n_w   = NW'(count_r);
  assign lc_w  = lchild(pos_r);
  assign rc_w  = lc_w + NW'(1);

  always_comb begin
    take_l = (lc_w < n_w) && ($signed(rd_a) < $signed(x_r));
    best_l = take_l ? rd_a : x_r;
    take_r = (rc_w < n_w) && ($signed(rd_b) < $signed(best_l));
    if (take_r) begin
      best_pos = rc_w[AW-1:0];
      best_val = rd_b;
    end else if (take_l) begin
      best_pos = lc_w[AW-1:0];
      best_val = rd_a;
    end else begin
      best_pos = pos_r;
      best_val = x_r;
    end
    blc_w = lchild(best_pos);
    brc_w = blc_w + NW'(1);
  end

  always_comb begin
    state_nxt  = state_r;
    x_nxt      = x_r;
    pos_nxt    = pos_r;
    bp_nxt     = bp_r;
    count_nxt  = count_r;
    root_nxt   = root_r;
    we         = 1'b0;
    wa         = pos_r;
    wd         = x_r;
    ra         = pos_r;
    rb         = pos_r;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_rdata  = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_opcode)
            OP_INSERT, OP_APPEND: begin
              if (count_r == CW'(CAPACITY)) begin
                fin        = 1'b1;
                fin_status = ST_FULL;
              end else begin
                count_nxt = count_r + CW'(1);
                x_nxt     = vin;
                pos_nxt   = AW'(count_r);
                if (in_opcode == OP_APPEND || count_r == '0) begin
                  we  = 1'b1;
                  wa  = AW'(count_r);
                  wd  = vin;
                  fin = 1'b1;
                end else begin
                  ra        = AW'((count_r - CW'(1)) >> 1);
                  state_nxt = S_UP;
                end
              end
            end
            OP_BUILD: begin
              if (half == '0) begin
                fin = 1'b1;
              end else begin
                pos_nxt   = AW'(half - CW'(1));
                bp_nxt    = AW'(half - CW'(1));
                ra        = AW'(half - CW'(1));
                state_nxt = S_DN_LOAD;
              end
            end
            OP_READ: begin
              if (XW'(in_index) < XW'(count_r)) begin
                ra        = AW'(in_index);
                state_nxt = S_RD;
              end else begin
                fin        = 1'b1;
                fin_status = ST_RANGE;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_UP: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end else if ($signed(rd_a) > $signed(x_r)) begin
          we      = 1'b1;
          wd      = rd_a;
          pos_nxt = par;
          ra      = (par - AW'(1)) >> 1;
        end else begin
          we        = 1'b1;
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DN_LOAD: begin
        x_nxt     = rd_a;
        ra        = lc_w[AW-1:0];
        rb        = rc_w[AW-1:0];
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (take_l || take_r) begin
          wd      = best_val;
          pos_nxt = best_pos;
          ra      = blc_w[AW-1:0];
          rb      = brc_w[AW-1:0];
        end else if (bp_r == '0) begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          bp_nxt    = bp_r - AW'(1);
          pos_nxt   = bp_r - AW'(1);
          ra        = bp_r - AW'(1);
          state_nxt = S_DN_LOAD;
        end
      end
      S_RD: begin
        fin       = 1'b1;
        fin_rdata = rd_a;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (we && wa == '0) begin
      root_nxt = wd;
    end
  end

  assign total_ext = (CW + OUT_TOTAL_W)'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    pos_r  <= pos_nxt;
    bp_r   <= bp_nxt;
    root_r <= root_nxt;
    if (fin) begin
      out_read_data_r   <= to32(fin_rdata);
      out_min_value_r   <= (count_nxt != '0) ? to32(root_nxt) : 32'sd0;
      out_entry_total_r <= total_ext[OUT_TOTAL_W-1:0];
      out_status_r      <= fin_status;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_read_data   = out_read_data_r;
  assign out_min_value   = out_min_value_r;
  assign out_entry_total = out_entry_total_r;
  assign out_status      = out_status_r;

endmodule
